// ----- hw/rtl/afc_pkg.sv -----
`default_nettype none
package afc_pkg;

	// Frame layout: bytes the checks read, and where each field lies
	localparam logic [5:0] FRAME_NEEDED = 6'd42;
	localparam logic [5:0] DEST_END     = 6'd6;
	localparam logic [5:0] OPCODE_LO    = 6'd20;
	localparam logic [5:0] OPCODE_HI    = 6'd21;
	localparam logic [5:0] SHA_LO       = 6'd22;
	localparam logic [5:0] SHA_HI       = 6'd27;
	localparam logic [5:0] SPA_LO       = 6'd28;
	localparam logic [5:0] SPA_HI       = 6'd31;
	localparam logic [5:0] THA_LO       = 6'd32;
	localparam logic [5:0] THA_HI       = 6'd37;
	localparam logic [5:0] TPA_LO       = 6'd38;
	localparam logic [5:0] TPA_HI       = 6'd41;

	localparam logic [15:0] OP_REQUEST = 16'd1;
	localparam logic [15:0] OP_REPLY   = 16'd2;

	// Frame summaries waiting between capture and classification
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		VERDICT_REPORT       = 4'd0,
		VERDICT_SHORT        = 4'd1,
		VERDICT_NOT_BCAST    = 4'd2,
		VERDICT_REPLY_ANNC   = 4'd3,
		VERDICT_NOT_REQUEST  = 4'd4,
		VERDICT_PROBE        = 4'd5,
		VERDICT_ANNOUNCE     = 4'd6,
		VERDICT_LOCAL        = 4'd7,
		VERDICT_STOPPED      = 4'd8
	} verdict_t;

	typedef enum logic [2:0] {
		REG_SUBNET_MASK   = 3'd0,
		REG_LOCAL_NETWORK = 3'd1,
		REG_ACCEPT_PROBES = 3'd2,
		REG_ACCEPT_ANNC   = 3'd3,
		REG_REPORT_ALL    = 3'd4,
		REG_STOP_FIRST    = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} frame_t;

	typedef struct packed {
		verdict_t    verdict;
		logic        report;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
	} result_t;

	typedef struct packed {
		logic [31:0] subnet_mask;
		logic [31:0] local_network;
		logic        accept_probes;
		logic        accept_announcements;
		logic        report_all_networks;
		logic        stop_after_first;
	} cfg_t;

	// Everything the classifier needs from one captured frame
	typedef struct packed {
		logic        len_ok;
		logic        dest_bcast;
		logic [15:0] opcode;
		logic [47:0] sender_hw;
		logic [31:0] sender_proto;
		logic [47:0] target_hw;
		logic [31:0] target_proto;
	} frame_rec_t;

endpackage
`default_nettype wire

// ----- hw/rtl/afc_capture.sv -----
`default_nettype none
module afc_capture (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  afc_pkg::frame_t      in_data,
	output logic                 push,
	output afc_pkg::frame_rec_t  push_rec,
	input  wire                  queue_full
);

	logic [5:0]  pos_q;
	logic        bcast_q;
	logic [15:0] opcode_q;
	logic [47:0] sha_q;
	logic [31:0] spa_q;
	logic [47:0] tha_q;
	logic [31:0] tpa_q;

	logic [5:0]  pos_d;
	logic        bcast_d;
	logic [15:0] opcode_d;
	logic [47:0] sha_d;
	logic [31:0] spa_d;
	logic [47:0] tha_d;
	logic [31:0] tpa_d;
	logic        take;

	assign in_ready = !queue_full;
	assign take     = in_valid && in_ready;
	assign push     = take && in_data.frame_end;

	// Shift the current byte into the field its position selects
	always_comb begin
		bcast_d  = bcast_q;
		opcode_d = opcode_q;
		sha_d    = sha_q;
		spa_d    = spa_q;
		tha_d    = tha_q;
		tpa_d    = tpa_q;
		if (pos_q < afc_pkg::DEST_END) begin
			if (in_data.frame_byte != 8'hFF) begin
				bcast_d = 1'b0;
			end
		end else if (pos_q inside {[afc_pkg::OPCODE_LO:afc_pkg::OPCODE_HI]}) begin
			opcode_d = {opcode_q[7:0], in_data.frame_byte};
		end else if (pos_q inside {[afc_pkg::SHA_LO:afc_pkg::SHA_HI]}) begin
			sha_d = {sha_q[39:0], in_data.frame_byte};
		end else if (pos_q inside {[afc_pkg::SPA_LO:afc_pkg::SPA_HI]}) begin
			spa_d = {spa_q[23:0], in_data.frame_byte};
		end else if (pos_q inside {[afc_pkg::THA_LO:afc_pkg::THA_HI]}) begin
			tha_d = {tha_q[39:0], in_data.frame_byte};
		end else if (pos_q inside {[afc_pkg::TPA_LO:afc_pkg::TPA_HI]}) begin
			tpa_d = {tpa_q[23:0], in_data.frame_byte};
		end
		pos_d = (pos_q < afc_pkg::FRAME_NEEDED) ? pos_q + 6'd1 : pos_q;
	end

	// Summary of the frame including its last byte
	always_comb begin
		push_rec.len_ok       = (pos_d == afc_pkg::FRAME_NEEDED);
		push_rec.dest_bcast   = bcast_d;
		push_rec.opcode       = opcode_d;
		push_rec.sender_hw    = sha_d;
		push_rec.sender_proto = spa_d;
		push_rec.target_hw    = tha_d;
		push_rec.target_proto = tpa_d;
	end

	// Advance capture per byte; clear for the next frame after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			bcast_q  <= 1'b1;
			opcode_q <= '0;
			sha_q    <= '0;
			spa_q    <= '0;
			tha_q    <= '0;
			tpa_q    <= '0;
		end else if (take) begin
			if (in_data.frame_end) begin
				pos_q    <= '0;
				bcast_q  <= 1'b1;
				opcode_q <= '0;
				sha_q    <= '0;
				spa_q    <= '0;
				tha_q    <= '0;
				tpa_q    <= '0;
			end else begin
				pos_q    <= pos_d;
				bcast_q  <= bcast_d;
				opcode_q <= opcode_d;
				sha_q    <= sha_d;
				spa_q    <= spa_d;
				tha_q    <= tha_d;
				tpa_q    <= tpa_d;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/afc_queue.sv -----
`default_nettype none
module afc_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  afc_pkg::frame_rec_t  push_rec,
	output logic                 full,
	input  wire                  pop,
	output logic                 head_valid,
	output afc_pkg::frame_rec_t  head_rec
);

	localparam logic [afc_pkg::QPTR_W-1:0] LAST_SLOT = afc_pkg::QPTR_W'(afc_pkg::QUEUE_DEPTH - 1);
	localparam logic [afc_pkg::QCNT_W-1:0] DEPTH_CNT = afc_pkg::QCNT_W'(afc_pkg::QUEUE_DEPTH);

	afc_pkg::frame_rec_t slot_q [afc_pkg::QUEUE_DEPTH];
	logic [afc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [afc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [afc_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full       = (count_q == DEPTH_CNT);
	assign head_valid = (count_q != '0);
	assign head_rec   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_rec;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + afc_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + afc_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + afc_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - afc_pkg::QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/afc_classify.sv -----
`default_nettype none
module afc_classify (
	input  wire                  clk,
	input  wire                  arst_n,
	input  afc_pkg::cfg_t        cfg,
	input  wire                  head_valid,
	input  afc_pkg::frame_rec_t  head_rec,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output afc_pkg::result_t     out_data
);

	logic              match_seen_q;
	logic              out_valid_q;
	afc_pkg::result_t  result_q;
	afc_pkg::verdict_t verdict;
	logic              same_ip;
	logic              reply_annc;

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = result_q;

	// Run the checks in priority order on the queue head
	always_comb begin
		same_ip    = (head_rec.sender_proto == head_rec.target_proto);
		reply_annc = (head_rec.opcode == afc_pkg::OP_REPLY) && same_ip &&
			(head_rec.sender_hw == head_rec.target_hw);
		verdict = afc_pkg::VERDICT_REPORT;
		if (cfg.stop_after_first && match_seen_q) begin
			verdict = afc_pkg::VERDICT_STOPPED;
		end else if (!head_rec.len_ok) begin
			verdict = afc_pkg::VERDICT_SHORT;
		end else if (!head_rec.dest_bcast) begin
			verdict = afc_pkg::VERDICT_NOT_BCAST;
		end else if (reply_annc && !cfg.accept_announcements) begin
			verdict = afc_pkg::VERDICT_REPLY_ANNC;
		end else if (!reply_annc && head_rec.opcode != afc_pkg::OP_REQUEST) begin
			verdict = afc_pkg::VERDICT_NOT_REQUEST;
		end else if (!reply_annc && head_rec.sender_hw == '0 && !cfg.accept_probes) begin
			verdict = afc_pkg::VERDICT_PROBE;
		end else if (!reply_annc && same_ip && !cfg.accept_announcements) begin
			verdict = afc_pkg::VERDICT_ANNOUNCE;
		end else if ((head_rec.sender_proto & cfg.subnet_mask) == cfg.local_network &&
			!cfg.report_all_networks) begin
			verdict = afc_pkg::VERDICT_LOCAL;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.verdict    <= verdict;
			result_q.report     <= (verdict == afc_pkg::VERDICT_REPORT);
			result_q.sender_mac <= head_rec.sender_hw;
			result_q.sender_ip  <= head_rec.sender_proto;
			result_q.target_ip  <= head_rec.target_proto;
		end
	end

	// Output valid and the first-match latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			match_seen_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && verdict == afc_pkg::VERDICT_REPORT && cfg.stop_after_first) begin
				match_seen_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/arp_frame_classifier.sv -----
// Accepts one frame byte per cycle; a frame's verdict passes from the transaction that carries
// its last byte through a four-entry queue and an output register.
// Sustained throughput is one byte per cycle; input stalls only when four verdicts are
// queued behind an output register that the receiver is holding off.
// Asynchronous active-low reset clears capture state, queue, first-match latch and registers.
`default_nettype none
module arp_frame_classifier (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               frame_valid,
	output logic              frame_ready,
	input  afc_pkg::frame_t   frame,
	output logic              result_valid,
	input  wire               result_ready,
	output afc_pkg::result_t  result,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [4:0]         paddr,
	input  wire [31:0]        pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	afc_pkg::cfg_t       cfg_q;
	afc_pkg::frame_rec_t push_rec;
	afc_pkg::frame_rec_t head_rec;
	afc_pkg::reg_index_t reg_index;
	logic push;
	logic pop;
	logic queue_full;
	logic head_valid;
	logic cfg_write;

	assign pready    = 1'b1;
	assign reg_index = afc_pkg::reg_index_t'(paddr[4:2]);
	assign cfg_write = psel && penable && pwrite;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (reg_index)
				afc_pkg::REG_SUBNET_MASK:   cfg_q.subnet_mask          <= pwdata;
				afc_pkg::REG_LOCAL_NETWORK: cfg_q.local_network        <= pwdata;
				afc_pkg::REG_ACCEPT_PROBES: cfg_q.accept_probes        <= pwdata[0];
				afc_pkg::REG_ACCEPT_ANNC:   cfg_q.accept_announcements <= pwdata[0];
				afc_pkg::REG_REPORT_ALL:    cfg_q.report_all_networks  <= pwdata[0];
				afc_pkg::REG_STOP_FIRST:    cfg_q.stop_after_first     <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back configuration
	always_comb begin
		case (reg_index)
			afc_pkg::REG_SUBNET_MASK:   prdata = cfg_q.subnet_mask;
			afc_pkg::REG_LOCAL_NETWORK: prdata = cfg_q.local_network;
			afc_pkg::REG_ACCEPT_PROBES: prdata = {31'd0, cfg_q.accept_probes};
			afc_pkg::REG_ACCEPT_ANNC:   prdata = {31'd0, cfg_q.accept_announcements};
			afc_pkg::REG_REPORT_ALL:    prdata = {31'd0, cfg_q.report_all_networks};
			afc_pkg::REG_STOP_FIRST:    prdata = {31'd0, cfg_q.stop_after_first};
			default:                    prdata = '0;
		endcase
	end

	afc_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (frame_valid),
		.in_ready   (frame_ready),
		.in_data    (frame),
		.push       (push),
		.push_rec   (push_rec),
		.queue_full (queue_full)
	);

	afc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	afc_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.out_valid  (result_valid),
		.out_ready  (result_ready),
		.out_data   (result)
	);

endmodule
`default_nettype wire

// ----- sim/arp_frame_classifier_tb.sv -----
`default_nettype none
module arp_frame_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import afc_pkg::*;

	localparam int DRAIN_CYCLES  = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_BYTES  = 480;
	localparam int SEGMENT_BYTES = 40;

	// Ethertype, hardware type, protocol type, address lengths
	localparam logic [63:0] ARP_HEADER = 64'h0806_0001_0800_0604;

	localparam logic [47:0] BCAST     = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] MAC_A     = 48'h021A_2B3C_4D5E;
	localparam logic [47:0] MAC_B     = 48'hF0E1_D2C3_B4A5;
	localparam logic [47:0] MAC_ONES  = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] IP_FAR    = 32'h0A00_0005;
	localparam logic [31:0] IP_GW     = 32'hC0A8_0101;
	localparam logic [31:0] IP_NEAR   = 32'hC0A8_0107;
	localparam logic [31:0] MASK24    = 32'hFFFF_FF00;
	localparam logic [31:0] NET_LOCAL = 32'hC0A8_0100;

	// Option bits: probes, announcements, all networks, stop after first
	localparam logic [3:0] F_PROBES = 4'b1000;
	localparam logic [3:0] F_ANNC   = 4'b0100;
	localparam logic [3:0] F_ALL    = 4'b0010;
	localparam logic [3:0] F_STOP   = 4'b0001;

	typedef struct packed {
		logic [47:0] dest;
		logic [15:0] opcode;
		logic [47:0] sha;
		logic [31:0] spa;
		logic [47:0] tha;
		logic [31:0] tpa;
	} arp_fields_t;

	typedef struct packed {
		arp_fields_t fields;
		logic [6:0]  len;
		logic [3:0]  flags;
		logic [31:0] mask;
		logic [31:0] net;
		logic        typed;
		verdict_t    want;
	} frame_row_t;

	logic        clk;
	logic        arst_n;
	logic        frame_valid;
	logic        frame_ready;
	frame_t      frame;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predictor copy of the capture state and the registers
	logic [5:0]  cap_pos;
	logic        cap_bcast;
	logic [15:0] cap_opcode;
	logic [47:0] cap_sha;
	logic [47:0] cap_tha;
	logic [31:0] cap_spa;
	logic [31:0] cap_tpa;
	logic        first_match_seen;
	cfg_t        cur_cfg;

	result_t     expected_verdicts[$];
	frame_row_t  stimulus_rows[$];
	int          errors;
	int          verdicts_seen;
	int          bytes_sent;
	int          tx_idle_pct;
	int          rx_stall_pct;
	bit          hold_req;

	arp_frame_classifier uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("arp_frame_classifier verification failed");
		$finish;
	end

	function automatic logic [47:0] rand_mac();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	function void clear_capture();
		cap_pos    = '0;
		cap_bcast  = 1'b1;
		cap_opcode = '0;
		cap_sha    = '0;
		cap_tha    = '0;
		cap_spa    = '0;
		cap_tpa    = '0;
	endfunction

	// Decide the verdict of the frame just closed, first failing check wins
	function verdict_t classify_frame();
		logic same_ip;
		same_ip = cap_spa == cap_tpa;
		if (cur_cfg.stop_after_first && first_match_seen) return VERDICT_STOPPED;
		if (cap_pos < FRAME_NEEDED) return VERDICT_SHORT;
		if (!cap_bcast) return VERDICT_NOT_BCAST;
		if (cap_opcode == OP_REPLY && same_ip && cap_sha == cap_tha) begin
			if (!cur_cfg.accept_announcements) return VERDICT_REPLY_ANNC;
		end else begin
			if (cap_opcode != OP_REQUEST) return VERDICT_NOT_REQUEST;
			if (cap_sha == '0 && !cur_cfg.accept_probes) return VERDICT_PROBE;
			if (same_ip && !cur_cfg.accept_announcements) return VERDICT_ANNOUNCE;
		end
		if ((cap_spa & cur_cfg.subnet_mask) == cur_cfg.local_network
				&& !cur_cfg.report_all_networks)
			return VERDICT_LOCAL;
		return VERDICT_REPORT;
	endfunction

	// Capture one accepted byte; queue a verdict at the end of the frame
	function void absorb_byte(frame_t f);
		result_t  r;
		verdict_t v;
		if (cap_pos < DEST_END) begin
			if (f.frame_byte != 8'hFF) cap_bcast = 1'b0;
		end else if (cap_pos >= OPCODE_LO && cap_pos <= OPCODE_HI) begin
			cap_opcode = {cap_opcode[7:0], f.frame_byte};
		end else if (cap_pos >= SHA_LO && cap_pos <= SHA_HI) begin
			cap_sha = {cap_sha[39:0], f.frame_byte};
		end else if (cap_pos >= SPA_LO && cap_pos <= SPA_HI) begin
			cap_spa = {cap_spa[23:0], f.frame_byte};
		end else if (cap_pos >= THA_LO && cap_pos <= THA_HI) begin
			cap_tha = {cap_tha[39:0], f.frame_byte};
		end else if (cap_pos >= TPA_LO && cap_pos <= TPA_HI) begin
			cap_tpa = {cap_tpa[23:0], f.frame_byte};
		end
		if (cap_pos < FRAME_NEEDED) cap_pos = cap_pos + 6'd1;
		if (f.frame_end) begin
			v = classify_frame();
			if (v == VERDICT_REPORT && cur_cfg.stop_after_first) first_match_seen = 1'b1;
			r.verdict    = v;
			r.report     = v == VERDICT_REPORT;
			r.sender_mac = cap_sha;
			r.sender_ip  = cap_spa;
			r.target_ip  = cap_tpa;
			expected_verdicts.push_back(r);
			clear_capture();
		end
	endfunction

	function automatic logic [7:0] byte_at(arp_fields_t a, int p);
		logic [7:0] b;
		if (p < 6) b = a.dest[47 - 8*p -: 8];
		else if (p < 12) b = a.sha[47 - 8*(p - 6) -: 8];
		else if (p < 20) b = ARP_HEADER[63 - 8*(p - 12) -: 8];
		else if (p < 22) b = a.opcode[15 - 8*(p - 20) -: 8];
		else if (p < 28) b = a.sha[47 - 8*(p - 22) -: 8];
		else if (p < 32) b = a.spa[31 - 8*(p - 28) -: 8];
		else if (p < 38) b = a.tha[47 - 8*(p - 32) -: 8];
		else if (p < 42) b = a.tpa[31 - 8*(p - 38) -: 8];
		else b = 8'($urandom_range(255));
		return b;
	endfunction

	// Offer one byte, with a random gap before it, and hold until accepted
	task automatic send_byte(frame_t f);
		if ($urandom_range(99) < tx_idle_pct) begin
			frame_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		frame_valid <= 1'b1;
		frame       <= f;
		do @(posedge clk); while (!frame_ready);
		absorb_byte(f);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic frame_out(arp_fields_t a, int len, bit noise);
		frame_t fb;
		for (int p = 0; p < len; p++) begin
			fb.frame_byte = noise ? 8'($urandom_range(255)) : byte_at(a, p);
			fb.frame_end  = p == len - 1;
			send_byte(fb);
		end
	endtask

	// One write transfer; the bus stays selected so writes can follow back to back
	task automatic reg_write(reg_index_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	// Drain the block, then write every register
	task automatic apply_cfg(cfg_t c);
		frame_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		reg_write(REG_SUBNET_MASK, c.subnet_mask);
		reg_write(REG_LOCAL_NETWORK, c.local_network);
		reg_write(REG_ACCEPT_PROBES, {31'd0, c.accept_probes});
		reg_write(REG_ACCEPT_ANNC, {31'd0, c.accept_announcements});
		reg_write(REG_REPORT_ALL, {31'd0, c.report_all_networks});
		reg_write(REG_STOP_FIRST, {31'd0, c.stop_after_first});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_cfg = c;
	endtask

	function automatic cfg_t make_cfg(logic [31:0] mask, logic [31:0] net, logic [3:0] flags);
		cfg_t c;
		c.subnet_mask          = mask;
		c.local_network        = net;
		c.accept_probes        = flags[3];
		c.accept_announcements = flags[2];
		c.report_all_networks  = flags[1];
		c.stop_after_first     = flags[0];
		return c;
	endfunction

	function automatic frame_row_t frame_row(int len, logic [47:0] dest, logic [15:0] op,
			logic [47:0] sha, logic [31:0] spa, logic [47:0] tha, logic [31:0] tpa,
			logic [3:0] flags, logic [31:0] mask, logic [31:0] net,
			logic typed, verdict_t want);
		frame_row_t r;
		r.fields = '{dest: dest, opcode: op, sha: sha, spa: spa, tha: tha, tpa: tpa};
		r.len    = 7'(len);
		r.flags  = flags;
		r.mask   = mask;
		r.net    = net;
		r.typed  = typed;
		r.want   = want;
		return r;
	endfunction

	function automatic cfg_t segment_cfg(int seg);
		logic [31:0] mask;
		mask = ~(32'hFFFF_FFFF >> $urandom_range(32));
		case (seg % 6)
			0: return make_cfg(MASK24, NET_LOCAL, 4'($urandom_range(15)) & ~F_STOP);
			1: return make_cfg(32'h0, 32'h0, 4'b0000);
			2: return make_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'b1110);
			3: return make_cfg(mask, $urandom & mask, 4'($urandom_range(15)) & ~F_STOP);
			4: return make_cfg(32'hFFFF_0000, $urandom & 32'hFFFF_0000, 4'b1111);
			default: return make_cfg(32'h0, $urandom | 32'h1, 4'($urandom_range(15)) & ~F_STOP);
		endcase
	endfunction

	// Mostly well-formed ARP with random content, some short frames and noise
	task automatic send_random_frame();
		arp_fields_t a;
		int          kind;
		int          len;
		kind     = $urandom_range(99);
		a.dest   = ($urandom_range(9) == 0) ? rand_mac() : BCAST;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: a.opcode = OP_REQUEST;
			6, 7, 8: a.opcode = OP_REPLY;
			default: a.opcode = 16'($urandom_range(16'hFFFF));
		endcase
		case ($urandom_range(19))
			0, 1: a.sha = '0;
			2: a.sha = MAC_ONES;
			default: a.sha = rand_mac();
		endcase
		case ($urandom_range(9))
			0, 1, 2, 3: a.spa = (cur_cfg.local_network & cur_cfg.subnet_mask)
				| ($urandom & ~cur_cfg.subnet_mask);
			4: a.spa = ($urandom_range(1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
			default: a.spa = $urandom;
		endcase
		a.tha = ($urandom_range(9) < 3) ? a.sha : rand_mac();
		a.tpa = ($urandom_range(3) == 0) ? a.spa : $urandom;
		len   = ($urandom_range(4) == 0) ? $urandom_range(43, 60) : 42;
		if (kind < 70) frame_out(a, len, 1'b0);
		else if (kind < 85) frame_out(a, $urandom_range(1, 41), 1'b0);
		else frame_out(a, $urandom_range(1, 70), 1'b1);
	endtask

	task automatic set_idle_profile(int k);
		case (k % 4)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
			default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
		endcase
	endtask

	task check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
		end
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left    = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= $urandom_range(99) >= rx_stall_pct;
			end
		end
	end

	// Compare each result transaction with the oldest expected verdict
	initial begin
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				if (expected_verdicts.size() == 0) begin
					errors++;
					$display("%0t: result with no expectation, verdict %0d", $time,
						result.verdict);
				end else begin
					want = expected_verdicts.pop_front();
					check_field("verdict", 64'(want.verdict), 64'(result.verdict));
					check_field("report", 64'(want.report), 64'(result.report));
					check_field("sender_mac", 64'(want.sender_mac), 64'(result.sender_mac));
					check_field("sender_ip", 64'(want.sender_ip), 64'(result.sender_ip));
					check_field("target_ip", 64'(want.target_ip), 64'(result.target_ip));
					verdicts_seen++;
				end
			end
		end
	end

	initial begin
		frame_row_t  r;
		cfg_t        c;
		arp_fields_t noise_fields;
		int          random_start;
		int          seg;
		int          seg_end;
		arst_n           = 1'b0;
		frame_valid      = 1'b0;
		frame            = '0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		errors           = 0;
		verdicts_seen    = 0;
		bytes_sent       = 0;
		tx_idle_pct      = 0;
		rx_stall_pct     = 0;
		hold_req         = 1'b0;
		first_match_seen = 1'b0;
		cur_cfg          = '0;
		noise_fields     = '0;
		clear_capture();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames: len, dest, opcode, sha, spa, tha, tpa, options, mask, net
		stimulus_rows.push_back(frame_row(1, BCAST, OP_REQUEST, MAC_A, IP_FAR, '0, IP_GW,
			4'b0000, MASK24, NET_LOCAL, 1'b1, VERDICT_SHORT));
		stimulus_rows.push_back(frame_row(41, BCAST, OP_REQUEST, MAC_A, IP_FAR, '0, IP_GW,
			4'b0000, MASK24, NET_LOCAL, 1'b1, VERDICT_SHORT));
		stimulus_rows.push_back(frame_row(42, 48'hFFFF_FFFF_FFFE, OP_REQUEST, MAC_A, IP_FAR,
			'0, IP_GW, 4'b0000, MASK24, NET_LOCAL, 1'b1, VERDICT_NOT_BCAST));
		stimulus_rows.push_back(frame_row(42, 48'h0, OP_REQUEST, MAC_A, IP_FAR, '0, IP_GW,
			4'b0000, MASK24, NET_LOCAL, 1'b1, VERDICT_NOT_BCAST));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REQUEST, MAC_A, IP_FAR, '0, IP_GW,
			4'b0000, MASK24, NET_LOCAL, 1'b0, VERDICT_REPORT));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REQUEST, MAC_A, IP_NEAR, '0, IP_GW,
			4'b0000, MASK24, NET_LOCAL, 1'b0, VERDICT_REPORT));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REQUEST, MAC_A, IP_NEAR, '0, IP_GW,
			F_ALL, MASK24, NET_LOCAL, 1'b0, VERDICT_REPORT));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REPLY, MAC_A, IP_FAR, MAC_B, IP_GW,
			4'b0000, MASK24, NET_LOCAL, 1'b1, VERDICT_NOT_REQUEST));
		stimulus_rows.push_back(frame_row(42, BCAST, 16'h0000, MAC_A, IP_FAR, MAC_B, IP_GW,
			4'b0000, MASK24, NET_LOCAL, 1'b1, VERDICT_NOT_REQUEST));
		stimulus_rows.push_back(frame_row(42, BCAST, 16'hFFFF, MAC_A, IP_FAR, MAC_B, IP_GW,
			4'b0000, MASK24, NET_LOCAL, 1'b1, VERDICT_NOT_REQUEST));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REPLY, MAC_A, IP_FAR, MAC_A, IP_FAR,
			4'b0000, MASK24, NET_LOCAL, 1'b1, VERDICT_REPLY_ANNC));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REPLY, MAC_A, IP_FAR, MAC_A, IP_FAR,
			F_ANNC, MASK24, NET_LOCAL, 1'b0, VERDICT_REPORT));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REQUEST, '0, IP_FAR, '0, IP_GW,
			4'b0000, MASK24, NET_LOCAL, 1'b1, VERDICT_PROBE));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REQUEST, '0, IP_FAR, '0, IP_GW,
			F_PROBES, MASK24, NET_LOCAL, 1'b0, VERDICT_REPORT));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REQUEST, MAC_A, IP_FAR, '0, IP_FAR,
			4'b0000, MASK24, NET_LOCAL, 1'b1, VERDICT_ANNOUNCE));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REQUEST, MAC_A, IP_FAR, '0, IP_FAR,
			F_ANNC, MASK24, NET_LOCAL, 1'b0, VERDICT_REPORT));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REQUEST, MAC_A, IP_FAR, '0, IP_GW,
			F_STOP, MASK24, NET_LOCAL, 1'b0, VERDICT_REPORT));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REQUEST, MAC_B, IP_FAR, '0, IP_GW,
			F_STOP, MASK24, NET_LOCAL, 1'b1, VERDICT_STOPPED));
		stimulus_rows.push_back(frame_row(5, BCAST, OP_REQUEST, MAC_B, IP_FAR, '0, IP_GW,
			F_STOP, MASK24, NET_LOCAL, 1'b1, VERDICT_STOPPED));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REQUEST, MAC_B, IP_FAR, '0, IP_GW,
			4'b0000, MASK24, NET_LOCAL, 1'b0, VERDICT_REPORT));
		stimulus_rows.push_back(frame_row(64, BCAST, OP_REQUEST, MAC_ONES, 32'hFFFF_FFFF,
			MAC_ONES, 32'h0, 4'b0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, VERDICT_REPORT));
		stimulus_rows.push_back(frame_row(42, BCAST, OP_REQUEST, MAC_ONES, 32'h0, '0,
			32'hFFFF_FFFF, 4'b1110, 32'h0, 32'h0, 1'b0, VERDICT_REPORT));

		// Walk the table, rewriting registers only when the options, mask or network change
		for (int i = 0; i < stimulus_rows.size(); i++) begin
			r = stimulus_rows[i];
			set_idle_profile(i);
			c = make_cfg(r.mask, r.net, r.flags);
			if (i == 0 || c != cur_cfg) apply_cfg(c);
			frame_out(r.fields, r.len, 1'b0);
			if (r.typed) begin
				expected_verdicts[expected_verdicts.size() - 1].verdict = r.want;
				expected_verdicts[expected_verdicts.size() - 1].report  = r.want == VERDICT_REPORT;
			end
		end

		// Random segments, each with its own registers and idle profile
		random_start = bytes_sent;
		seg = 0;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			set_idle_profile(seg);
			apply_cfg(segment_cfg(seg));
			if (seg == 1) begin
				// Stall the output long enough to back the queue up into the input
				hold_req = 1'b1;
				repeat (16) frame_out(noise_fields, 1, 1'b1);
			end
			seg_end = bytes_sent + SEGMENT_BYTES;
			while (bytes_sent < seg_end) send_random_frame();
			seg++;
		end

		frame_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("arp_frame_classifier verification clean");
		end else begin
			$display("arp_frame_classifier verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
